// ===== rtl/wavetable_oscillator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Wavetable oscillator assertion macros
// Shorthand for clocked properties with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_UNIT_MACROS_SVH
`define WAVETABLE_OSCILLATOR_UNIT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define WTO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: property failed");

// consequent checked in the same cycle as the antecedent
`define WTO_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: property failed");

`endif

// ===== rtl/wto_pkg.sv =====
// ----------------------------------------------------------------------------
// wto_pkg
// Shared widths, codes and controller/datapath bundles of the wavetable
// oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package wto_pkg;

    localparam int PHASE_W    = 24;
    localparam int GAIN_W     = 16;
    localparam int WAVE_W     = 3;
    localparam int BAND_W     = 4;
    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 10;
    localparam int VALUE_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP  = 3'd0,
        CFG_WAVEFORM    = 3'd1,
        CFG_GAIN        = 3'd2,
        CFG_PULSE_WIDTH = 3'd3,
        CFG_BAND_SELECT = 3'd4
    } t_cfg_idx;

    // waveform codes; 5..7 behave as silent
    localparam logic [WAVE_W-1:0] WAVE_SILENT   = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_SINE     = 2'd0,
        KIND_SAW_UP   = 2'd1,
        KIND_SAW_DOWN = 2'd2,
        KIND_TRIANGLE = 2'd3
    } t_kind;

    typedef enum logic {
        MODE_TICK  = 1'b0,
        MODE_WRITE = 1'b1
    } t_mode;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd16384;
    localparam logic [PHASE_W-1:0] PW_RESET   = 24'd8388608;

    typedef struct packed {
        logic wr;
        logic clr_res;
        logic prep;
        logic rd_a;
        logic rd_b;
        logic diff;
        logic mult;
        logic acc;
        logic lk;
        logic scale;
        logic sat;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic silent;
        logic square;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/wto_in_if.sv =====
// ----------------------------------------------------------------------------
// wto_in_if
// Input channel: sample ticks and table entry writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface wto_in_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [wto_pkg::KIND_W-1:0]          table_kind;
    logic [wto_pkg::BAND_W-1:0]          band;
    logic [wto_pkg::ADDR_W-1:0]          entry_address;
    logic signed [wto_pkg::VALUE_W-1:0]  entry_value;

    modport source (
        output valid, mode, table_kind, band, entry_address, entry_value,
        input  ready
    );
    modport sink (
        input  valid, mode, table_kind, band, entry_address, entry_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/wto_out_if.sv =====
// ----------------------------------------------------------------------------
// wto_out_if
// Output channel: one oscillator sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wto_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [wto_pkg::VALUE_W-1:0]  sample;

    modport source (
        output valid, sample,
        input  ready
    );
    modport sink (
        input  valid, sample,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/wto_controller.sv =====
// ----------------------------------------------------------------------------
// wto_controller
// Sequencer for table lookups, scaling and output hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module wto_controller (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_mode,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire wto_pkg::t_dp_status  i_status,
    output wto_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PREP  = 10'b0000000010,
        S_RDA   = 10'b0000000100,
        S_RDB   = 10'b0000001000,
        S_DIFF  = 10'b0000010000,
        S_MULT  = 10'b0000100000,
        S_ACC   = 10'b0001000000,
        S_SCALE = 10'b0010000000,
        S_SAT   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_lk, n_lk;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_lk        = r_lk;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.lk    = r_lk;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_mode == wto_pkg::MODE_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        n_lk = 1'b0;
                        if (i_status.silent) begin
                            o_cmd.clr_res = 1'b1;
                            n_state       = S_OUT;
                        end else begin
                            n_state = S_PREP;
                        end
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_RDA;
            end
            S_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state    = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_status.square && !r_lk) begin
                    n_lk    = 1'b1;
                    n_state = S_PREP;
                end else begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lk        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lk        <= n_lk;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/wto_datapath.sv =====
// ----------------------------------------------------------------------------
// wto_datapath
// Configuration and phase registers, wave memory, interpolation, gain and
// saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module wto_datapath #(
    parameter int TABLE_SIZE = 1024,
    parameter int NUM_BANDS  = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire wto_pkg::t_dp_cmd                    i_cmd,
    output wto_pkg::t_dp_status                      o_status,
    input  wire logic                                i_cfg_we,
    input  wire logic [wto_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [wto_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic [wto_pkg::KIND_W-1:0]          i_table_kind,
    input  wire logic [wto_pkg::BAND_W-1:0]          i_band,
    input  wire logic [wto_pkg::ADDR_W-1:0]          i_entry_address,
    input  wire logic signed [wto_pkg::VALUE_W-1:0]  i_entry_value,
    output logic signed [wto_pkg::VALUE_W-1:0]       o_sample
);

    localparam int NUM_TABLES = 1 + 3 * NUM_BANDS;
    localparam int MEM_DEPTH  = TABLE_SIZE * NUM_TABLES;
    localparam int AW         = $clog2(MEM_DEPTH);
    localparam int IW         = $clog2(TABLE_SIZE);
    localparam int TNW        = $clog2(NUM_TABLES);
    localparam int PH         = wto_pkg::PHASE_W;
    localparam int PW         = PH + IW;
    localparam int VW         = wto_pkg::VALUE_W;

    logic [PH-1:0]               r_phase_step;
    logic [wto_pkg::WAVE_W-1:0]  r_waveform;
    logic [wto_pkg::GAIN_W-1:0]  r_gain;
    logic [PH-1:0]               r_pulse_width;
    logic [wto_pkg::BAND_W-1:0]  r_band_select;
    logic [PH-1:0]               r_phase;

    logic signed [VW-1:0]        r_mem [MEM_DEPTH];
    logic signed [VW-1:0]        r_rdata;

    logic [AW-1:0]               r_addr_a;
    logic [AW-1:0]               r_addr_b;
    logic [PH-1:0]               r_frac;
    logic signed [VW-1:0]        r_a;
    logic signed [VW:0]          r_diff;
    logic signed [VW+PH+1:0]     r_prod;
    logic signed [VW+1:0]        r_acc;
    logic signed [VW+wto_pkg::GAIN_W+2:0] r_mulg;
    logic signed [VW-1:0]        r_res;
    logic signed [VW-1:0]        r_sample;

    logic [TNW-1:0]              w_bsel;
    logic [PH-1:0]               w_half;
    logic [PH-1:0]               w_lk_phase;
    logic [TNW-1:0]              w_lk_tn;
    logic [PW-1:0]               w_prod;
    logic [IW-1:0]               w_idx;
    logic [IW-1:0]               w_nxt;
    logic [AW-1:0]               w_base;
    logic [TNW-1:0]              w_wr_tn;
    logic [AW-1:0]               w_wr_addr;
    logic                        w_wr_ok;
    logic signed [VW+PH+1:0]     w_prod_rnd;
    logic signed [VW+1:0]        w_interp;
    logic signed [VW+wto_pkg::GAIN_W+2:0] w_mulg_rnd;
    logic signed [VW+4:0]        w_q;
    logic signed [VW-1:0]        w_sat;

    // lookup table and phase
    always_comb begin
        w_bsel = (32'(r_band_select) >= 32'(NUM_BANDS)) ? TNW'(NUM_BANDS - 1)
                                                        : TNW'(r_band_select);
        w_half = {1'b0, r_pulse_width[PH-1:1]};
        case (r_waveform)
            wto_pkg::WAVE_SINE: begin
                w_lk_phase = r_phase;
                w_lk_tn    = '0;
            end
            wto_pkg::WAVE_SQUARE: begin
                w_lk_phase = i_cmd.lk ? (r_phase - w_half) : (r_phase + w_half);
                w_lk_tn    = i_cmd.lk ? (TNW'(1 + NUM_BANDS) + w_bsel)
                                      : (TNW'(1) + w_bsel);
            end
            wto_pkg::WAVE_SAW: begin
                w_lk_phase = r_phase;
                w_lk_tn    = TNW'(1) + w_bsel;
            end
            wto_pkg::WAVE_TRIANGLE: begin
                w_lk_phase = r_phase;
                w_lk_tn    = TNW'(1 + 2 * NUM_BANDS) + w_bsel;
            end
            default: begin
                w_lk_phase = r_phase;
                w_lk_tn    = '0;
            end
        endcase
        w_prod = PW'(w_lk_phase) * PW'(TABLE_SIZE);
        w_idx  = w_prod[PW-1:PH];
        w_nxt  = (w_idx == IW'(TABLE_SIZE - 1)) ? '0 : w_idx + IW'(1);
        w_base = AW'(w_lk_tn) * AW'(TABLE_SIZE);
    end

    // table write address
    always_comb begin
        if (i_table_kind == wto_pkg::KIND_SINE) begin
            w_wr_tn = '0;
        end else begin
            w_wr_tn = TNW'(32'd1 + (32'(i_table_kind) - 32'd1) * 32'(NUM_BANDS)
                           + 32'(i_band));
        end
        w_wr_addr = AW'(w_wr_tn) * AW'(TABLE_SIZE) + AW'(i_entry_address);
        w_wr_ok   = (32'(i_entry_address) < 32'(TABLE_SIZE)) &&
                    ((i_table_kind == wto_pkg::KIND_SINE) ||
                     (32'(i_band) < 32'(NUM_BANDS)));
    end

    // interpolation, gain rounding and saturation
    always_comb begin
        w_prod_rnd = r_prod + (VW+PH+2)'(1 << (PH - 1));
        w_interp   = {{2{r_a[VW-1]}}, r_a} + w_prod_rnd[VW+PH+1:PH];
        w_mulg_rnd = r_mulg + (VW+wto_pkg::GAIN_W+3)'(1 << 13);
        w_q        = w_mulg_rnd[VW+wto_pkg::GAIN_W+2:14];
        if (w_q > (VW+5)'(131071)) begin
            w_sat = VW'(131071);
        end else if (w_q < -(VW+5)'(131072)) begin
            w_sat = VW'(-131072);
        end else begin
            w_sat = w_q[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_wr_ok) begin
            r_mem[w_wr_addr] <= i_entry_value;
        end
        if (i_cmd.rd_a || i_cmd.rd_b) begin
            r_rdata <= r_mem[i_cmd.rd_b ? r_addr_b : r_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_addr_a <= w_base + AW'(w_idx);
            r_addr_b <= w_base + AW'(w_nxt);
            r_frac   <= w_prod[PH-1:0];
        end
        if (i_cmd.rd_b) begin
            r_a <= r_rdata;
        end
        if (i_cmd.diff) begin
            r_diff <= {r_rdata[VW-1], r_rdata} - {r_a[VW-1], r_a};
        end
        if (i_cmd.mult) begin
            r_prod <= r_diff * $signed({1'b0, r_frac});
        end
        if (i_cmd.acc) begin
            r_acc <= i_cmd.lk ? (r_acc + w_interp) : w_interp;
        end
        if (i_cmd.scale) begin
            r_mulg <= r_acc * $signed({1'b0, r_gain});
        end
        if (i_cmd.clr_res) begin
            r_res <= '0;
        end else if (i_cmd.sat) begin
            r_res <= w_sat;
        end
        if (i_cmd.load_out) begin
            r_sample <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= '0;
            r_waveform    <= wto_pkg::WAVE_SILENT;
            r_gain        <= wto_pkg::GAIN_RESET;
            r_pulse_width <= wto_pkg::PW_RESET;
            r_band_select <= '0;
            r_phase       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wto_pkg::CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data[PH-1:0];
                    wto_pkg::CFG_WAVEFORM:    r_waveform    <= i_cfg_data[wto_pkg::WAVE_W-1:0];
                    wto_pkg::CFG_GAIN:        r_gain        <= i_cfg_data[wto_pkg::GAIN_W-1:0];
                    wto_pkg::CFG_PULSE_WIDTH: r_pulse_width <= i_cfg_data[PH-1:0];
                    wto_pkg::CFG_BAND_SELECT: r_band_select <= i_cfg_data[wto_pkg::BAND_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.sat) begin
                r_phase <= r_phase + r_phase_step;
            end
        end
    end

    always_comb begin
        o_status.square = (r_waveform == wto_pkg::WAVE_SQUARE);
        o_status.silent = !(r_waveform inside {wto_pkg::WAVE_SINE, wto_pkg::WAVE_SQUARE,
                                               wto_pkg::WAVE_SAW, wto_pkg::WAVE_TRIANGLE});
    end

    assign o_sample = r_sample;

endmodule

`default_nettype wire

// ===== rtl/wavetable_oscillator_unit.sv =====
// ----------------------------------------------------------------------------
// wavetable_oscillator_unit
// Phase-accumulator oscillator with interpolated, band-limited wave tables.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  i_in     | in  | valid / ready     | mode, table_kind, band, entry_address,
//           |     |                   | entry_value
//  o_out    | out | valid / ready     | sample
//  i_cfg_*  | in  | we (no wait)      | idx, data
//
//  A table write keeps the unit idle. A tick does one lookup for sine, saw
//  and triangle, two for square, none when silent; each lookup is two reads
//  on the one memory read port, then subtract, multiply and accumulate steps.
//  Reset clears control, config and phase; wave memory is undefined until
//  written, with no clearing pass. The output register holds a sample while
//  the sink stalls; a tick finishing meanwhile waits for the slot to free.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_oscillator_unit #(
    parameter int TABLE_SIZE = 1024,
    parameter int NUM_BANDS  = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    wto_in_if.sink                                i_in,
    wto_out_if.source                             o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [wto_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [wto_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    wto_pkg::t_dp_cmd     w_cmd;
    wto_pkg::t_dp_status  w_status;
    logic                 w_in_ready;
    logic                 w_out_valid;
    logic signed [wto_pkg::VALUE_W-1:0] w_sample;

    wto_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    wto_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .NUM_BANDS  (NUM_BANDS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_table_kind    (i_in.table_kind),
        .i_band          (i_in.band),
        .i_entry_address (i_in.entry_address),
        .i_entry_value   (i_in.entry_value),
        .o_sample        (w_sample)
    );

    assign i_in.ready   = w_in_ready;
    assign o_out.valid  = w_out_valid;
    assign o_out.sample = w_sample;

endmodule

`default_nettype wire

// ===== rtl/wto_checker.sv =====
// ----------------------------------------------------------------------------
// wto_checker
// Port-level checks of the wavetable oscillator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wavetable_oscillator_unit_macros.svh"

module wto_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               i_in_ready,
    input wire logic                               i_in_mode,
    input wire logic                               i_out_valid,
    input wire logic                               i_out_ready,
    input wire logic signed [wto_pkg::VALUE_W-1:0] i_out_sample
);

    `WTO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `WTO_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_sample))
    `WTO_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_mode == wto_pkg::MODE_TICK, !i_in_ready)
    `WTO_ASSERT_NEXT(a_write_free, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_mode == wto_pkg::MODE_WRITE, i_in_ready)
    `WTO_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, $rose(i_out_valid), i_in_ready)

endmodule

bind wavetable_oscillator_unit wto_checker u_wto_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_mode    (i_in.mode),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample)
);

`default_nettype wire
